>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the rapid move duration unit. All expect the
// enclosing module to have clk_i and an active low rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define RMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition never holds outside reset.
`define RMD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> src/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared widths, codes and bundle types of the rapid move duration unit.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned RATE_W   = 24;
  localparam int unsigned MASK_W   = 3;
  localparam int unsigned POS_W    = 28;
  localparam int unsigned DIST_W   = 28;  // |end - start| < 2^28
  localparam int unsigned AXIS_W   = 4;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned DIV_CNT_W = $clog2(TIME_W);

  localparam logic [19:0] US_PER_S = 20'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL = 4'd0,
    CFG_X      = 4'd1,
    CFG_Y      = 4'd2,
    CFG_Z      = 4'd3,
    CFG_MASK   = 4'd4,
    CFG_A      = 4'd5,
    CFG_B      = 4'd6,
    CFG_C      = 4'd7
  } cfg_reg_e;

  typedef enum logic [AXIS_W-1:0] {
    AX_X = 4'd0,
    AX_Y = 4'd1,
    AX_Z = 4'd2,
    AX_A = 4'd3,
    AX_B = 4'd4,
    AX_C = 4'd5,
    AX_U = 4'd6,
    AX_V = 4'd7,
    AX_W = 4'd8
  } axis_e;

  typedef struct packed {
    logic              axis_ok;
    logic [RATE_W-1:0] rate;
  } rate_sel_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/rmd_if.sv
// ----------------------------------------------------------------------------
// rmd_in_if / rmd_out_if
// Valid/ready channels for axis requests and move results.
// ----------------------------------------------------------------------------
interface rmd_in_if;
  logic                             valid;
  logic                             ready;
  logic        [rmd_pkg::AXIS_W-1:0] axis_id;
  logic signed [rmd_pkg::POS_W-1:0]  start_pos;
  logic signed [rmd_pkg::POS_W-1:0]  end_pos;
  logic                             last_axis;

  modport source (output valid, axis_id, start_pos, end_pos, last_axis, input ready);
  modport sink   (input valid, axis_id, start_pos, end_pos, last_axis, output ready);
endinterface

interface rmd_out_if;
  logic                        valid;
  logic                        ready;
  logic [rmd_pkg::TIME_W-1:0]  duration_us;
  logic                        infinite_time_error;

  modport source (output valid, duration_us, infinite_time_error, input ready);
  modport sink   (input valid, duration_us, infinite_time_error, output ready);
endinterface

>>> src/rmd_cfg.sv
// ----------------------------------------------------------------------------
// rmd_cfg
// Rate registers and per-axis rate selection.
// ----------------------------------------------------------------------------
module rmd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rmd_pkg::RATE_W-1:0]      cfg_data_i,
  input  logic [rmd_pkg::AXIS_W-1:0]      axis_id_i,
  output rmd_pkg::rate_sel_t              rate_sel_o
);

  logic [rmd_pkg::RATE_W-1:0] global_q, x_q, y_q, z_q, a_q, b_q, c_q;
  logic [rmd_pkg::MASK_W-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
      a_q      <= '0;
      b_q      <= '0;
      c_q      <= '0;
      mask_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmd_pkg::CFG_GLOBAL: global_q <= cfg_data_i;
        rmd_pkg::CFG_X:      x_q      <= cfg_data_i;
        rmd_pkg::CFG_Y:      y_q      <= cfg_data_i;
        rmd_pkg::CFG_Z:      z_q      <= cfg_data_i;
        rmd_pkg::CFG_MASK:   mask_q   <= cfg_data_i[rmd_pkg::MASK_W-1:0];
        rmd_pkg::CFG_A:      a_q      <= cfg_data_i;
        rmd_pkg::CFG_B:      b_q      <= cfg_data_i;
        rmd_pkg::CFG_C:      c_q      <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_comb begin
    rate_sel_o.axis_ok = 1'b1;
    rate_sel_o.rate    = global_q;
    unique case (axis_id_i) inside
      rmd_pkg::AX_X: rate_sel_o.rate = mask_q[0] ? x_q : global_q;
      rmd_pkg::AX_Y: rate_sel_o.rate = mask_q[1] ? y_q : global_q;
      rmd_pkg::AX_Z: rate_sel_o.rate = mask_q[2] ? z_q : global_q;
      rmd_pkg::AX_A: rate_sel_o.rate = a_q;
      rmd_pkg::AX_B: rate_sel_o.rate = b_q;
      rmd_pkg::AX_C: rate_sel_o.rate = c_q;
      rmd_pkg::AX_U, rmd_pkg::AX_V, rmd_pkg::AX_W: rate_sel_o.rate = global_q;
      default: rate_sel_o.axis_ok = 1'b0;
    endcase
  end

endmodule

>>> src/rmd_div.sv
// ----------------------------------------------------------------------------
// rmd_div
// Restoring divider, one quotient bit per cycle on a shared subtract/compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmd_pkg::div_req_t  req_i,
  output rmd_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned TW = rmd_pkg::TIME_W;
  localparam int unsigned RW = rmd_pkg::RATE_W;
  localparam int unsigned CW = rmd_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dvs_q, dvs_d;
  logic [TW-1:0] quo_q, quo_d;

  logic [RW:0]   shifted;
  logic [RW+1:0] trial;
  logic          ge;

  // Dividend bits leave the top of quo_q while quotient bits enter below.
  assign shifted = {rem_q, quo_q[TW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~trial[RW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(TW - 1);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? trial[RW-1:0] : shifted[RW-1:0];
      quo_d = {quo_q[TW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `RMD_ASSERT(a_start_idle, req_i.start |-> !busy_q, "divider restarted while busy")
  `RMD_ASSERT(a_done_after_last, busy_q && cnt_q == '0 |=> done_q && !busy_q, "divider missed done")
  `RMD_ASSERT_NEVER(a_busy_and_done, busy_q && done_q, "divider busy and done together")

endmodule

>>> src/rapid_move_duration_unit.sv
// ----------------------------------------------------------------------------
// rapid_move_duration_unit
// Time of a rapid move in microseconds, set by its slowest axis.
// ----------------------------------------------------------------------------
// One axis request is accepted at a time. A request with a nonzero rate passes
// from acceptance through the travel multiply (|end - start| * 1e6) in ST_MUL,
// the serial divider in ST_DIV (one quotient bit per cycle on its single
// subtract/compare), the divider flagging done and the running maximum update
// in ST_UPD before the unit is ready again. An axis with zero rate or an unknown
// id skips the divider and goes from ST_MUL straight to ST_UPD. The move
// result sits in an output register; new requests are accepted while it waits,
// but a request marked last holds in the update step until that register has
// been taken. time = floor(travel * 1e6 / rate) always fits 48 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rapid_move_duration_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rmd_pkg::RATE_W-1:0]    cfg_data_i,
  rmd_in_if.sink                        in_i,
  rmd_out_if.source                     out_o
);

  localparam int unsigned TW = rmd_pkg::TIME_W;
  localparam int unsigned RW = rmd_pkg::RATE_W;
  localparam int unsigned DW = rmd_pkg::DIST_W;
  localparam int unsigned PW = rmd_pkg::POS_W;

  localparam logic [TW-1:0] US_PER_S_W = TW'(rmd_pkg::US_PER_S);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

  state_e st_q, st_d;

  rmd_pkg::rate_sel_t rate_sel;
  rmd_pkg::div_req_t  div_req;
  rmd_pkg::div_rsp_t  div_rsp;

  logic [RW-1:0] rate_q;
  logic          axis_ok_q;
  logic [DW-1:0] dist_q;
  logic          last_q;
  logic          use_div_q, use_div_d;
  logic [TW-1:0] max_q, max_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic [TW-1:0] out_dur_q;
  logic          out_err_q;

  logic          accept;
  logic          out_free;
  logic          emit;
  logic [PW:0]   diff;
  logic [PW:0]   diff_abs;
  logic [TW-1:0] upd_max;

  rmd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .axis_id_i  (in_i.axis_id),
    .rate_sel_o (rate_sel)
  );

  rmd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (st_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  assign diff     = {in_i.end_pos[PW-1], in_i.end_pos}
                  - {in_i.start_pos[PW-1], in_i.start_pos};
  assign diff_abs = diff[PW] ? (~diff + 1'b1) : diff;

  assign div_req.start    = (st_q == ST_MUL) && axis_ok_q && (rate_q != '0);
  assign div_req.dividend = dist_q * US_PER_S_W;
  assign div_req.divisor  = rate_q;

  assign upd_max = (use_div_q && (div_rsp.quotient > max_q)) ? div_rsp.quotient : max_q;
  assign emit    = (st_q == ST_UPD) && last_q && out_free;

  always_comb begin
    st_d      = st_q;
    use_div_d = use_div_q;
    max_d     = max_q;
    err_d     = err_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) st_d = ST_MUL;
      end
      ST_MUL: begin
        use_div_d = div_req.start;
        if (div_req.start) begin
          st_d = ST_DIV;
        end else begin
          if (axis_ok_q && (dist_q != '0)) err_d = 1'b1;
          st_d = ST_UPD;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) st_d = ST_UPD;
      end
      ST_UPD: begin
        if (!last_q) begin
          max_d = upd_max;
          st_d  = ST_IDLE;
        end else if (out_free) begin
          max_d = '0;
          err_d = 1'b0;
          st_d  = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      use_div_q   <= 1'b0;
      max_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      use_div_q   <= use_div_d;
      max_q       <= max_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rate_q    <= rate_sel.rate;
      axis_ok_q <= rate_sel.axis_ok;
      dist_q    <= diff_abs[DW-1:0];
      last_q    <= in_i.last_axis;
    end
    if (emit) begin
      out_dur_q <= upd_max;
      out_err_q <= err_q;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.duration_us         = out_dur_q;
  assign out_o.infinite_time_error = out_err_q;

  `RMD_ASSERT_NEVER(a_div_zero, div_req.start && (div_req.divisor == '0), "divide by zero rate")
  `RMD_ASSERT(a_div_live, st_q == ST_DIV |-> div_rsp.busy || div_rsp.done, "divider idle in DIV")
  `RMD_ASSERT(a_clear_after_emit, emit |=> (max_q == '0) && !err_q, "move state not cleared")
  `RMD_ASSERT(a_hold_blocked, (st_q == ST_UPD) && last_q && !out_free |=> st_q == ST_UPD, "result overrun")

endmodule

>>> verif/tb_rapid_move_duration_unit.sv
// ----------------------------------------------------------------------------
// tb_rapid_move_duration_unit
// Self-checking bench for the rapid move duration unit. Axis requests are
// driven on the input channel and every accepted one is fed to a slowest-axis
// time predictor. Move results are checked field by field, in order, against
// the predicted queue. Directed moves cover the extreme travels, the zero rate
// cases, the unknown axis ids and the override selection. Random moves follow
// under several rate settings and handshake idle patterns, including a long
// output hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_rapid_move_duration_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIME_W    = rmd_pkg::TIME_W;
  localparam int unsigned POS_W     = rmd_pkg::POS_W;
  localparam int unsigned RATE_W    = rmd_pkg::RATE_W;
  localparam int unsigned AXIS_W    = rmd_pkg::AXIS_W;
  localparam int unsigned CFG_IDX_W = rmd_pkg::CFG_IDX_W;
  localparam int unsigned MASK_W    = rmd_pkg::MASK_W;

  localparam int unsigned SETTLE_CYCLES = 64;    // longer than one divider pass
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned STALL_LIMIT   = 8000;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned NUM_PHASES    = 8;

  localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 64'd1;
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [RATE_W-1:0]       RATE_MAX = {RATE_W{1'b1}};

  typedef enum int {CFG_RANDOM, CFG_ALL_MAX, CFG_ALL_ONE} cfg_style_e;

  typedef struct {
    logic [AXIS_W-1:0]       axis_id;
    logic signed [POS_W-1:0] start_pos;
    logic signed [POS_W-1:0] end_pos;
    logic                    last_axis;
  } axis_req_t;

  typedef struct {
    logic [TIME_W-1:0] duration_us;
    logic              infinite_time_error;
  } move_time_t;

  // Slowest-axis time predictor plus the queue of move times it owes.
  class move_time_board;
    logic [RATE_W-1:0] rate_reg [8];
    logic [TIME_W-1:0] longest_time;
    logic              zero_rate_hit;
    move_time_t        expected_moves [$];
    int                errors;

    function new();
      foreach (rate_reg[i]) rate_reg[i] = '0;
      longest_time  = '0;
      zero_rate_hit = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
      if (idx == rmd_pkg::CFG_MASK) begin
        rate_reg[rmd_pkg::CFG_MASK] = RATE_W'(val[MASK_W-1:0]);
      end else if (idx <= rmd_pkg::CFG_C) begin
        rate_reg[idx[2:0]] = val;
      end
    endfunction

    function void note_axis(axis_req_t r);
      logic [RATE_W-1:0] rate;
      logic [MASK_W-1:0] ovr;
      bit                known;
      longint            span;
      longint unsigned   travel;
      longint unsigned   t;
      ovr   = rate_reg[rmd_pkg::CFG_MASK][MASK_W-1:0];
      rate  = rate_reg[rmd_pkg::CFG_GLOBAL];
      known = 1'b1;
      case (r.axis_id) inside
        rmd_pkg::AX_X: if (ovr[0]) rate = rate_reg[rmd_pkg::CFG_X];
        rmd_pkg::AX_Y: if (ovr[1]) rate = rate_reg[rmd_pkg::CFG_Y];
        rmd_pkg::AX_Z: if (ovr[2]) rate = rate_reg[rmd_pkg::CFG_Z];
        rmd_pkg::AX_A: rate = rate_reg[rmd_pkg::CFG_A];
        rmd_pkg::AX_B: rate = rate_reg[rmd_pkg::CFG_B];
        rmd_pkg::AX_C: rate = rate_reg[rmd_pkg::CFG_C];
        rmd_pkg::AX_U, rmd_pkg::AX_V, rmd_pkg::AX_W: ;
        default: known = 1'b0;
      endcase
      if (known) begin
        span   = longint'($signed(r.end_pos)) - longint'($signed(r.start_pos));
        travel = (span < 0) ? longint'(-span) : longint'(span);
        if (rate == '0) begin
          if (travel != 0) zero_rate_hit = 1'b1;
        end else begin
          t = (travel * longint'(rmd_pkg::US_PER_S)) / longint'(rate);
          if (t > TIME_MAX) t = TIME_MAX;
          if (t > longest_time) longest_time = t[TIME_W-1:0];
        end
      end
      if (r.last_axis) begin
        expected_moves.push_back('{longest_time, zero_rate_hit});
        longest_time  = '0;
        zero_rate_hit = 1'b0;
      end
    endfunction

    function void check_move(logic [TIME_W-1:0] dur, logic err);
      move_time_t want;
      if (expected_moves.size() == 0) begin
        $error("unexpected move result: duration_us %0d infinite_time_error %0b", dur, err);
        errors++;
        return;
      end
      want = expected_moves.pop_front();
      if (dur !== want.duration_us) begin
        $error("duration_us: expected %0d, actual %0d", want.duration_us, dur);
        errors++;
      end
      if (err !== want.infinite_time_error) begin
        $error("infinite_time_error: expected %0b, actual %0b",
               want.infinite_time_error, err);
        errors++;
      end
    endfunction

    function int pending();
      return expected_moves.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [RATE_W-1:0]    cfg_data_i = '0;

  rmd_in_if  in_if ();
  rmd_out_if out_if ();

  rapid_move_duration_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  move_time_board board = new();
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_long_hold = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.axis_id   = '0;
    in_if.start_pos = '0;
    in_if.end_pos   = '0;
    in_if.last_axis = 1'b0;
  end

  // Result side ready; the long hold-off is timed here, not by the sender.
  initial begin : result_sink
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_long_hold) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_long_hold = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        board.note_axis('{in_if.axis_id, in_if.start_pos, in_if.end_pos, in_if.last_axis});
      end
      if (out_if.valid && out_if.ready) begin
        board.check_move(out_if.duration_us, out_if.infinite_time_error);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("rapid_move_duration_unit regression: fail");
    $finish;
  end

  function automatic axis_req_t mk(logic [AXIS_W-1:0] axis, logic signed [POS_W-1:0] s,
                                   logic signed [POS_W-1:0] e, logic last);
    axis_req_t r;
    r.axis_id   = axis;
    r.start_pos = s;
    r.end_pos   = e;
    r.last_axis = last;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(5))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return '0;
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    case ($urandom_range(9))
      0:       return '0;
      1:       return RATE_W'(1);
      2:       return RATE_MAX;
      3:       return RATE_W'($urandom_range(1, 1000));
      default: return RATE_W'($urandom());
    endcase
  endfunction

  // Entered and left on a falling edge; valid stays up after acceptance.
  task automatic send_axis(axis_req_t r);
    bit took;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.axis_id   = r.axis_id;
    in_if.start_pos = r.start_pos;
    in_if.end_pos   = r.end_pos;
    in_if.last_axis = r.last_axis;
    do begin
      @(posedge clk_i);
      took = in_if.ready;
      @(negedge clk_i);
    end while (!took);
  endtask

  // Sender stops, all owed results come back, then in-flight axes settle.
  task automatic drain();
    in_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    board.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic load_config(cfg_style_e style);
    rmd_pkg::cfg_reg_e r;
    logic [RATE_W-1:0] val;
    r = r.first();
    do begin
      case (style)
        CFG_ALL_MAX: val = (r == rmd_pkg::CFG_MASK) ? RATE_W'(3'b111) : RATE_MAX;
        CFG_ALL_ONE: val = (r == rmd_pkg::CFG_MASK) ? RATE_W'(3'b000) : RATE_W'(1);
        default:     val = (r == rmd_pkg::CFG_MASK) ? RATE_W'($urandom()) : rand_rate();
      endcase
      write_reg(r, val);
      r = r.next();
    end while (r != r.first());
    // indexes past the last register must be ignored
    write_reg(CFG_IDX_W'($urandom_range(rmd_pkg::CFG_C + 1, (1 << CFG_IDX_W) - 1)),
              RATE_W'($urandom()));
    cfg_we_i = 1'b0;
  endtask

  task automatic random_move(output int n);
    axis_req_t r;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        r.axis_id = AXIS_W'($urandom_range(rmd_pkg::AX_W + 1, 15));
      end else begin
        r.axis_id = AXIS_W'($urandom_range(rmd_pkg::AX_X, rmd_pkg::AX_W));
      end
      r.start_pos = rand_pos();
      case ($urandom_range(3))
        0:       r.end_pos = r.start_pos;
        1:       r.end_pos = r.start_pos + POS_W'($urandom_range(0, 2000)) - POS_W'(1000);
        default: r.end_pos = rand_pos();
      endcase
      r.last_axis = (i == n - 1);
      send_axis(r);
    end
  endtask

  initial begin : stimulus
    int n;
    int phase_items;
    int idle_modes [4][2];

    idle_modes = '{'{0, 0}, '{83, 0}, '{0, 83}, '{28, 28}};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all rates still zero from reset: any travel is an infinite time
    send_axis(mk(rmd_pkg::AX_X, '0, 28'sd5, 1'b1));
    send_axis(mk(rmd_pkg::AX_W, 28'sd3, 28'sd3, 1'b1));
    drain();

    write_reg(rmd_pkg::CFG_GLOBAL, 24'd12345);
    write_reg(rmd_pkg::CFG_X, 24'd1);
    write_reg(rmd_pkg::CFG_Y, RATE_MAX);
    write_reg(rmd_pkg::CFG_Z, '0);
    write_reg(rmd_pkg::CFG_MASK, 24'b011);
    write_reg(rmd_pkg::CFG_A, 24'd1000);
    write_reg(rmd_pkg::CFG_B, '0);
    write_reg(rmd_pkg::CFG_C, RATE_MAX);
    cfg_we_i = 1'b0;
    send_axis(mk(rmd_pkg::AX_X, POS_MIN, POS_MAX, 1'b0));   // longest time the unit can see
    send_axis(mk(rmd_pkg::AX_Y, POS_MAX, POS_MIN, 1'b1));
    send_axis(mk(rmd_pkg::AX_Z, '0, '0, 1'b1));             // Z follows global, no travel
    send_axis(mk(rmd_pkg::AX_B, 28'sd100, -28'sd100, 1'b1)); // zero rate with travel
    send_axis(mk(rmd_pkg::AX_B, 28'sd5, 28'sd5, 1'b1));      // zero rate, no travel
    send_axis(mk(rmd_pkg::AX_A, 28'sd1000, -28'sd1000, 1'b0));
    send_axis(mk(rmd_pkg::AX_C, POS_MIN, '0, 1'b0));
    send_axis(mk(rmd_pkg::AX_U, '0, 28'sd12345, 1'b0));
    send_axis(mk(rmd_pkg::AX_V, -28'sd1, 28'sd1, 1'b0));
    send_axis(mk(rmd_pkg::AX_W, 28'sd7, -28'sd7, 1'b1));
    // unknown ids add nothing
    send_axis(mk(AXIS_W'(rmd_pkg::AX_W + 1), POS_MIN, POS_MAX, 1'b0));
    send_axis(mk(AXIS_W'(15), '0, POS_MAX, 1'b1));
    send_axis(mk(AXIS_W'(12), 28'sd1, 28'sd2, 1'b1));
    drain();

    load_config(CFG_ALL_MAX);
    send_axis(mk(rmd_pkg::AX_Z, POS_MIN, POS_MAX, 1'b0));
    send_axis(mk(rmd_pkg::AX_B, POS_MAX, POS_MIN, 1'b0));
    send_axis(mk(rmd_pkg::AX_X, '0, 28'sd1, 1'b1));         // rounds down to zero
    drain();

    load_config(CFG_ALL_ONE);
    send_axis(mk(rmd_pkg::AX_X, POS_MAX, POS_MIN, 1'b0));
    send_axis(mk(rmd_pkg::AX_Z, 28'sd1, '0, 1'b1));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct  = idle_modes[p % 4][0];
      rx_stall_pct = idle_modes[p % 4][1];
      case (p)
        0:       load_config(CFG_ALL_MAX);
        1:       load_config(CFG_ALL_ONE);
        default: load_config(CFG_RANDOM);
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          // stray request with no move structure around it
          send_axis(mk(AXIS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
                       1'($urandom())));
          n = 1;
        end else begin
          random_move(n);
        end
        phase_items += n;
      end
      drain();
    end

    // output held off while requests keep coming: the unit backs up
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    load_config(CFG_RANDOM);
    rx_long_hold = 1'b1;
    phase_items  = 0;
    while (phase_items < 40) begin
      random_move(n);
      phase_items += n;
    end
    drain();

    if (board.errors == 0) begin
      $display("rapid_move_duration_unit regression: pass");
    end else begin
      $display("rapid_move_duration_unit regression: fail");
    end
    $finish;
  end

endmodule
